// ===== rtl/flag_pkg.sv =====
// ----------------------------------------------------------------------------
// flag_pkg: shared types and constants for the arrow geometry core
// Sequencer states, multiply-accumulate controls, register indexes and the
// fixed rotation constants for the arrowhead wings.
// ----------------------------------------------------------------------------
package flag_pkg;

  typedef enum logic [4:0] {
    S_IDLE, S_DXX, S_DYY, S_D2, S_LD, S_LL, S_LLW, S_CHK,
    S_SQ, S_DSET, S_DIV, S_TX, S_TY, S_TXW, S_TYW, S_TD,
    S_R1, S_R2, S_R3, S_R4, S_R5, S_R6, S_R7, S_OUT
  } state_t;

  typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;

  typedef enum logic [2:0] {A_DX, A_DY, A_D2, A_LEN, A_UX, A_UY, A_ROT} a_sel_t;

  typedef enum logic [2:0] {B_DX, B_DY, B_K, B_LEN, B_COS, B_SIN} b_sel_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t op;
  } mac_ctrl_t;

  typedef enum logic [1:0] {REG_CX, REG_CY, REG_LEN} reg_idx_t;

  localparam int COS6_Q30   = 1067859754;
  localparam int SIN6_Q30   = 112236583;
  localparam int NEAR_SCALE = 10000;
  localparam int LEN_RESET  = 100;
  localparam int SQ_STEPS   = 25;
  localparam int REM_W      = 28;

  // round half up from Q30 down to Q f
  function automatic int q30_round(input int v, input int f);
    return (v + (1 <<< (29 - f))) >>> (30 - f);
  endfunction

endpackage

// ===== rtl/flag_if.sv =====
// ----------------------------------------------------------------------------
// flag_target_if / flag_result_if: request channels of the arrow core
// Valid/ready channels with the target point and the arrow geometry result.
// ----------------------------------------------------------------------------
interface flag_target_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;

  modport source (output valid, target_x, target_y, input ready);
  modport sink   (input valid, target_x, target_y, output ready);
endinterface

interface flag_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] tip_x;
  logic signed [15:0] tip_y;
  logic signed [15:0] left_wing_x;
  logic signed [15:0] left_wing_y;
  logic signed [15:0] right_wing_x;
  logic signed [15:0] right_wing_y;
  logic               tip_held;

  modport source (output valid, tip_x, tip_y, left_wing_x, left_wing_y,
                  right_wing_x, right_wing_y, tip_held, input ready);
  modport sink   (input valid, tip_x, tip_y, left_wing_x, left_wing_y,
                  right_wing_x, right_wing_y, tip_held, output ready);
endinterface

// ===== rtl/flag_mac.sv =====
// ----------------------------------------------------------------------------
// flag_mac: shared multiply-accumulate unit
// Registered signed product followed by an accumulator that loads, adds or
// subtracts it under sequencer control.
// ----------------------------------------------------------------------------
module flag_mac #(
  parameter int MA = 35,
  parameter int MB = 18
) (
  input  logic                     clk,
  input  flag_pkg::mac_ctrl_t      ctrl,
  input  logic signed [MA-1:0]     a,
  input  logic signed [MB-1:0]     b,
  output logic signed [MA+MB-1:0]  acc
);

  logic signed [MA+MB-1:0] p;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      p <= a * b;
    end
    case (ctrl.op)
      flag_pkg::ACC_LOAD: acc <= p;
      flag_pkg::ACC_ADD:  acc <= acc + p;
      flag_pkg::ACC_SUB:  acc <= acc - p;
      default:            acc <= acc;
    endcase
  end

endmodule

// ===== rtl/flag_csub.sv =====
// ----------------------------------------------------------------------------
// flag_csub: shared compare and subtract
// One step of the bit-serial square root and of the restoring divider.
// ----------------------------------------------------------------------------
module flag_csub #(
  parameter int W = 28
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         ge,
  output logic [W-1:0] diff
);

  logic [W:0] d;

  assign d    = {1'b0, a} - {1'b0, b};
  assign ge   = ~d[W];
  assign diff = d[W-1:0];

endmodule

// ===== rtl/fixed_length_arrow_geometry_core.sv =====
// ----------------------------------------------------------------------------
// fixed_length_arrow_geometry_core: fixed-length arrow tip and arrowhead
// Throughput: one request at a time; the square root (25 steps) and the two
//   divisions per unit vector run one bit a cycle on one compare-subtract unit.
// Reset: clears the sequencer and the output valid, center to 0, length to
//   100 and the stored tip to 0; no clearing pass.
// ----------------------------------------------------------------------------
module fixed_length_arrow_geometry_core #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_idx,
  input  logic [15:0]          cfg_data,
  flag_target_if.sink          target,
  flag_result_if.source        result
);

  localparam int F      = FRAC_BITS;
  localparam int UW     = F + 2;
  localparam int RW     = F + 3;
  localparam int MA     = 35;
  localparam int MB     = (F + 2 > 17) ? F + 2 : 17;
  localparam int AW     = MA + MB;
  localparam int WW     = F + 20;
  localparam int KSTEPS = F + 2;
  localparam int RMW    = flag_pkg::REM_W;
  localparam int COS_I  = flag_pkg::q30_round(flag_pkg::COS6_Q30, F);
  localparam int SIN_I  = flag_pkg::q30_round(flag_pkg::SIN6_Q30, F);
  localparam logic signed [WW-1:0] SAT_HI = WW'((longint'(1) <<< (COORD_BITS - 1)) - 1);
  localparam logic signed [WW-1:0] SAT_LO = -SAT_HI - WW'(1);
  localparam logic [UW-1:0] ONE_U = UW'(1) << F;

  flag_pkg::state_t  state, state_next;
  flag_pkg::mac_ctrl_t mctrl;
  flag_pkg::a_sel_t  a_sel;
  flag_pkg::b_sel_t  b_sel;

  logic signed [15:0] cx, cy, prev_x, prev_y, tx, ty, lx, ly, rx, ry;
  logic [14:0]        len;
  logic signed [16:0] dx, dy;
  logic               held, ph, comp;
  logic [1:0]         wi;
  logic [49:0]        xs;
  logic [24:0]        root;
  logic [RMW-1:0]     rem;
  logic [UW-1:0]      q;
  logic [4:0]         cnt;
  logic signed [UW-1:0] ux, uy;
  logic signed [RW-1:0] rot;
  logic               rv;

  logic signed [MA-1:0] mac_a;
  logic signed [MB-1:0] mac_b;
  logic signed [AW-1:0] acc;
  logic [RMW-1:0]       cs_a, cs_b, cs_diff;
  logic                 cs_ge;
  logic [16:0]          mag_x, mag_y;
  logic [UW-1:0]        qn, uclip;
  logic signed [UW-1:0] u_val;
  logic signed [AW-1:0] rsum;
  logic signed [WW-1:0] sval, sres;
  logic [WW-1:0]        smag, sshr;
  logic signed [15:0]   st, csel, wtip;
  logic                 acc_pos, tip_on_center, out_free;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      cx  <= '0;
      cy  <= '0;
      len <= 15'(flag_pkg::LEN_RESET);
    end else if (cfg_we) begin
      case (cfg_idx)
        flag_pkg::REG_CX:  cx  <= cfg_data;
        flag_pkg::REG_CY:  cy  <= cfg_data;
        flag_pkg::REG_LEN: len <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- units
  flag_mac #(.MA(MA), .MB(MB)) u_mac (
    .clk (clk),
    .ctrl(mctrl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  assign cs_a = (state == flag_pkg::S_SQ) ? {rem[25:0], xs[49:48]} : {rem[RMW-2:0], 1'b0};
  assign cs_b = (state == flag_pkg::S_SQ) ? {1'b0, root, 2'b01} : {3'b0, root};

  flag_csub #(.W(RMW)) u_csub (
    .a   (cs_a),
    .b   (cs_b),
    .ge  (cs_ge),
    .diff(cs_diff)
  );

  always_comb begin
    case (a_sel)
      flag_pkg::A_DX:  mac_a = MA'(dx);
      flag_pkg::A_DY:  mac_a = MA'(dy);
      flag_pkg::A_D2:  mac_a = $signed({1'b0, acc[33:0]});
      flag_pkg::A_LEN: mac_a = $signed({{(MA-15){1'b0}}, len});
      flag_pkg::A_UX:  mac_a = MA'(ux);
      flag_pkg::A_UY:  mac_a = MA'(uy);
      flag_pkg::A_ROT: mac_a = MA'(rot);
      default:         mac_a = '0;
    endcase
    case (b_sel)
      flag_pkg::B_DX:  mac_b = MB'(dx);
      flag_pkg::B_DY:  mac_b = MB'(dy);
      flag_pkg::B_K:   mac_b = MB'(flag_pkg::NEAR_SCALE);
      flag_pkg::B_LEN: mac_b = $signed({{(MB-15){1'b0}}, len});
      flag_pkg::B_COS: mac_b = MB'(COS_I);
      flag_pkg::B_SIN: mac_b = MB'(SIN_I);
      default:         mac_b = '0;
    endcase
  end

  // ---------------------------------------------------------------- helpers
  assign mag_x   = dx[16] ? 17'(-dx) : 17'(dx);
  assign mag_y   = dy[16] ? 17'(-dy) : 17'(dy);
  assign qn      = {q[UW-2:0], cs_ge};
  assign uclip   = (qn > ONE_U) ? ONE_U : qn;
  assign u_val   = (comp ? dy[16] : dx[16]) ? -$signed(uclip) : $signed(uclip);
  assign rsum    = acc + (AW'(1) <<< (F - 1));
  assign acc_pos = !acc[AW-1] && (acc != '0);
  assign tip_on_center = (tx == cx) && (ty == cy);
  assign out_free = !rv || result.ready;

  // truncate toward zero and saturate, for tip and wing coordinates
  always_comb begin
    csel = (state == flag_pkg::S_TYW) ? cy : cx;
    wtip = wi[0] ? ty : tx;
    if (state == flag_pkg::S_R7) begin
      sval = (WW'(wtip) <<< (F + 1)) - WW'(acc);
      smag = sval[WW-1] ? WW'(-sval) : WW'(sval);
      sshr = smag >> (F + 1);
    end else begin
      sval = (WW'(csel) <<< F) + WW'(acc);
      smag = sval[WW-1] ? WW'(-sval) : WW'(sval);
      sshr = smag >> F;
    end
    sres = sval[WW-1] ? -$signed(sshr) : $signed(sshr);
    if (sres > SAT_HI) begin
      st = 16'(SAT_HI);
    end else if (sres < SAT_LO) begin
      st = 16'(SAT_LO);
    end else begin
      st = 16'(sres);
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    case (state)
      flag_pkg::S_IDLE: if (target.valid) state_next = flag_pkg::S_DXX;
      flag_pkg::S_DXX:  state_next = flag_pkg::S_DYY;
      flag_pkg::S_DYY:  state_next = flag_pkg::S_D2;
      flag_pkg::S_D2:   state_next = flag_pkg::S_LD;
      flag_pkg::S_LD:   state_next = ph ? flag_pkg::S_SQ : flag_pkg::S_LL;
      flag_pkg::S_LL:   state_next = flag_pkg::S_LLW;
      flag_pkg::S_LLW:  state_next = flag_pkg::S_CHK;
      flag_pkg::S_CHK:  state_next = acc_pos ? flag_pkg::S_SQ : flag_pkg::S_TD;
      flag_pkg::S_SQ: begin
        if (cnt == 5'(flag_pkg::SQ_STEPS - 1)) state_next = flag_pkg::S_DSET;
      end
      flag_pkg::S_DSET: state_next = flag_pkg::S_DIV;
      flag_pkg::S_DIV: begin
        if (cnt == 5'(KSTEPS - 1) && comp) begin
          state_next = ph ? flag_pkg::S_R1 : flag_pkg::S_TX;
        end
      end
      flag_pkg::S_TX:   state_next = flag_pkg::S_TY;
      flag_pkg::S_TY:   state_next = flag_pkg::S_TXW;
      flag_pkg::S_TXW:  state_next = flag_pkg::S_TYW;
      flag_pkg::S_TYW:  state_next = flag_pkg::S_TD;
      flag_pkg::S_TD:   state_next = tip_on_center ? flag_pkg::S_OUT : flag_pkg::S_DXX;
      flag_pkg::S_R1:   state_next = flag_pkg::S_R2;
      flag_pkg::S_R2:   state_next = flag_pkg::S_R3;
      flag_pkg::S_R3:   state_next = flag_pkg::S_R4;
      flag_pkg::S_R4:   state_next = flag_pkg::S_R5;
      flag_pkg::S_R5:   state_next = flag_pkg::S_R6;
      flag_pkg::S_R6:   state_next = flag_pkg::S_R7;
      flag_pkg::S_R7:   state_next = (wi == 2'd3) ? flag_pkg::S_OUT : flag_pkg::S_R1;
      flag_pkg::S_OUT:  if (out_free) state_next = flag_pkg::S_IDLE;
      default:          state_next = flag_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mctrl.mul_en = 1'b0;
    mctrl.op     = flag_pkg::ACC_NONE;
    a_sel        = flag_pkg::A_DX;
    b_sel        = flag_pkg::B_DX;
    case (state)
      flag_pkg::S_DXX: begin
        mctrl.mul_en = 1'b1;
      end
      flag_pkg::S_DYY: begin
        mctrl.mul_en = 1'b1;
        mctrl.op     = flag_pkg::ACC_LOAD;
        a_sel        = flag_pkg::A_DY;
        b_sel        = flag_pkg::B_DY;
      end
      flag_pkg::S_D2:  mctrl.op = flag_pkg::ACC_ADD;
      flag_pkg::S_LD: begin
        mctrl.mul_en = !ph;
        a_sel        = flag_pkg::A_D2;
        b_sel        = flag_pkg::B_K;
      end
      flag_pkg::S_LL: begin
        mctrl.mul_en = 1'b1;
        mctrl.op     = flag_pkg::ACC_LOAD;
        a_sel        = flag_pkg::A_LEN;
        b_sel        = flag_pkg::B_LEN;
      end
      flag_pkg::S_LLW: mctrl.op = flag_pkg::ACC_SUB;
      flag_pkg::S_TX: begin
        mctrl.mul_en = 1'b1;
        a_sel        = flag_pkg::A_UX;
        b_sel        = flag_pkg::B_LEN;
      end
      flag_pkg::S_TY: begin
        mctrl.mul_en = 1'b1;
        mctrl.op     = flag_pkg::ACC_LOAD;
        a_sel        = flag_pkg::A_UY;
        b_sel        = flag_pkg::B_LEN;
      end
      flag_pkg::S_TXW: mctrl.op = flag_pkg::ACC_LOAD;
      flag_pkg::S_R1: begin
        mctrl.mul_en = 1'b1;
        a_sel        = wi[0] ? flag_pkg::A_UY : flag_pkg::A_UX;
        b_sel        = flag_pkg::B_COS;
      end
      flag_pkg::S_R2: begin
        mctrl.mul_en = 1'b1;
        mctrl.op     = flag_pkg::ACC_LOAD;
        a_sel        = wi[0] ? flag_pkg::A_UX : flag_pkg::A_UY;
        b_sel        = flag_pkg::B_SIN;
      end
      flag_pkg::S_R3:  mctrl.op = (wi[0] ^ wi[1]) ? flag_pkg::ACC_SUB : flag_pkg::ACC_ADD;
      flag_pkg::S_R5: begin
        mctrl.mul_en = 1'b1;
        a_sel        = flag_pkg::A_ROT;
        b_sel        = flag_pkg::B_LEN;
      end
      flag_pkg::S_R6:  mctrl.op = flag_pkg::ACC_LOAD;
      default: ;
    endcase
  end

  assign target.ready = (state == flag_pkg::S_IDLE);
  assign result.valid = rv;

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= flag_pkg::S_IDLE;
      rv     <= 1'b0;
      ph     <= 1'b0;
      prev_x <= '0;
      prev_y <= '0;
    end else begin
      state <= state_next;
      if (state == flag_pkg::S_IDLE) begin
        ph <= 1'b0;
      end else if (state == flag_pkg::S_TD) begin
        ph <= 1'b1;
      end
      // store the new tip
      if (state == flag_pkg::S_TYW) begin
        prev_x <= tx;
        prev_y <= st;
      end
      if (state == flag_pkg::S_OUT && out_free) begin
        rv <= 1'b1;
      end else if (result.ready) begin
        rv <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    case (state)
      flag_pkg::S_IDLE: begin
        dx <= {target.target_x[15], target.target_x} - {cx[15], cx};
        dy <= {target.target_y[15], target.target_y} - {cy[15], cy};
      end
      flag_pkg::S_LD: begin
        xs   <= {acc[33:0], 16'b0};
        root <= '0;
        rem  <= '0;
        cnt  <= '0;
      end
      flag_pkg::S_CHK: begin
        held <= !acc_pos;
        if (!acc_pos) begin
          tx <= prev_x;
          ty <= prev_y;
        end
      end
      flag_pkg::S_SQ: begin
        rem  <= cs_ge ? cs_diff : cs_a;
        root <= {root[23:0], cs_ge};
        xs   <= xs << 2;
        cnt  <= cnt + 5'd1;
      end
      flag_pkg::S_DSET: begin
        rem  <= {5'b0, mag_x, 6'b0};
        q    <= '0;
        cnt  <= '0;
        comp <= 1'b0;
      end
      flag_pkg::S_DIV: begin
        rem <= cs_ge ? cs_diff : cs_a;
        q   <= qn;
        cnt <= cnt + 5'd1;
        if (cnt == 5'(KSTEPS - 1)) begin
          cnt <= '0;
          if (!comp) begin
            ux   <= u_val;
            comp <= 1'b1;
            rem  <= {5'b0, mag_y, 6'b0};
            q    <= '0;
          end else begin
            uy <= u_val;
          end
        end
      end
      flag_pkg::S_TXW: tx <= st;
      flag_pkg::S_TYW: ty <= st;
      flag_pkg::S_TD: begin
        wi <= '0;
        // tip on the centre: wings collapse onto the tip
        if (tip_on_center) begin
          lx <= tx;
          rx <= tx;
          ly <= ty;
          ry <= ty;
        end else begin
          dx <= {tx[15], tx} - {cx[15], cx};
          dy <= {ty[15], ty} - {cy[15], cy};
        end
      end
      flag_pkg::S_R4: rot <= rsum[F +: RW];
      flag_pkg::S_R7: begin
        wi <= wi + 2'd1;
        case (wi)
          2'd0:    lx <= st;
          2'd1:    ly <= st;
          2'd2:    rx <= st;
          default: ry <= st;
        endcase
      end
      flag_pkg::S_OUT: begin
        if (out_free) begin
          result.tip_x        <= tx;
          result.tip_y        <= ty;
          result.left_wing_x  <= lx;
          result.left_wing_y  <= ly;
          result.right_wing_x <= rx;
          result.right_wing_y <= ry;
          result.tip_held     <= held;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/flag_chk.sv =====
// ----------------------------------------------------------------------------
// flag_chk: port-level checks for the arrow geometry core
// Watches the request and result channels over time.
// ----------------------------------------------------------------------------
module flag_chk (
  input logic        clk,
  input logic        rst,
  input logic        t_valid,
  input logic        t_ready,
  input logic        r_valid,
  input logic        r_ready,
  input logic [15:0] r_tip_x,
  input logic [15:0] r_tip_y,
  input logic        r_tip_held
);

  // hold a stalled result
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (r_valid && !r_ready) |=> (r_valid && $stable(r_tip_x) && $stable(r_tip_y)
                               && $stable(r_tip_held)))
    else $error("stalled result changed");

  // one request in flight: ready drops after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (t_valid && t_ready) |=> !t_ready)
    else $error("ready stayed high after accept");

  // a new result appears only as the sequencer returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(r_valid) |-> t_ready)
    else $error("result raised while busy");

  a_reset_state: assert property (@(posedge clk)
    rst |=> (t_ready && !r_valid))
    else $error("bad state after reset");

endmodule

bind fixed_length_arrow_geometry_core flag_chk u_flag_chk (
  .clk       (clk),
  .rst       (rst),
  .t_valid   (target.valid),
  .t_ready   (target.ready),
  .r_valid   (result.valid),
  .r_ready   (result.ready),
  .r_tip_x   (result.tip_x),
  .r_tip_y   (result.tip_y),
  .r_tip_held(result.tip_held)
);
